>>> rtl/heightmap_slope_curvature_defines.svh
// Assertion macros for the checker file of the slope and curvature block.
`ifndef HEIGHTMAP_SLOPE_CURVATURE_DEFINES_SVH
`define HEIGHTMAP_SLOPE_CURVATURE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hsc check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hsc check failed");

`endif

>>> rtl/hsc_pkg.sv
// Types and constants of the heightmap slope and curvature block.
`timescale 1ns / 1ps
package hsc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int SLOPE_W     = 16;
  localparam int CURV_W      = 24;
  localparam int POS_W       = 10;
  localparam int DIM_W       = 11;
  localparam int TILE_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE   = 2'd2;

  localparam logic [DIM_W-1:0]  GRID_WIDTH_RST  = 11'd64;
  localparam logic [DIM_W-1:0]  GRID_HEIGHT_RST = 11'd64;
  localparam logic [DIM_W-1:0]  POS_LIMIT       = 11'd1024;
  localparam logic [TILE_W-1:0] TILE_SIZE_RST   = 16'd256;

  // datapath widths
  localparam int EXT_W     = SAMPLE_BITS + 3;  // signed stencil sums
  localparam int DIF_W     = 16;               // |hr-hl|, |hu-hd|
  localparam int CD_W      = 18;               // second differences
  localparam int D_W       = 17;               // 2*tile
  localparam int P_W       = 35;               // d^2 + a^2 + b^2
  localparam int M_W       = 40;               // curvature energy
  localparam int S_W       = 48;               // tile^2 in Q.32, divisor width
  localparam int NUM_W     = 66;               // dividend width
  localparam int ROOT_IN_W = 64;
  localparam int ROOT_W    = 32;
  localparam int CURV_FRAC = SAMPLE_BITS + 2;  // dividend shift for curvature
  localparam int CURV_SH   = 24;               // 4^12 guard on the energy
  localparam int X_W       = 33;               // slope quotient, at most 2^32

  localparam logic [S_W-1:0]    CURV_MIN = 48'd429497;
  localparam logic [CURV_W-1:0] CURV_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic load;
    logic pick;
    logic mul;
    logic sum;
    logic div_go;
    logic div_curv;
    logic sqrt_go;
    logic sqrt_curv;
    logic emit;
  } hsc_cmd_t;

  typedef struct packed {
    logic jobs_left;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } hsc_sts_t;

endpackage

>>> rtl/hsc_if.sv
// Valid/ready channel interfaces for height samples and slope/curvature results.
`timescale 1ns / 1ps
interface hsc_sample_if import hsc_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] height_sample;

  modport source (output valid, height_sample, input ready);
  modport sink (input valid, height_sample, output ready);
endinterface

interface hsc_result_if import hsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOPE_W-1:0] slope;
  logic [CURV_W-1:0] curvature;
  logic [POS_W-1:0]  cell_col;
  logic [POS_W-1:0]  cell_row;
  logic              last_of_run;
  logic              last_of_grid;

  modport source (output valid, slope, curvature, cell_col, cell_row, last_of_run,
                  last_of_grid, input ready);
  modport sink (input valid, slope, curvature, cell_col, cell_row, last_of_run,
                last_of_grid, output ready);
endinterface

>>> rtl/hsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

>>> rtl/hsc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module hsc_div import hsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [S_W-1:0]   den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [S_W-1:0]   den_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [S_W:0]     rem_sh, rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[S_W-1:0] : rem_sh[S_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

>>> rtl/hsc_isqrt.sv
// Integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module hsc_isqrt import hsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ROOT_IN_W-1:0] val_i,
  output logic                 done_o,
  output logic [ROOT_W-1:0]    root_o
);
  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_IN_W-1:0] val_q;
  logic [REM_W-1:0]     rem_q, rem_sh, trial;
  logic [ROOT_W-1:0]    root_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q, ge;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], val_q[ROOT_IN_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[ROOT_IN_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

>>> rtl/hsc_ctrl.sv
// Sequencer: steps one sample through window update and each of its results.
`timescale 1ns / 1ps
module hsc_ctrl import hsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  hsc_sts_t sts_i,
  output hsc_cmd_t cmd_o,
  output logic     in_ready_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_NEXT, S_DIFF, S_MUL, S_SUM, S_DIVS, S_SQS, S_SQC, S_DIVC, S_EMIT
  } state_e;

  state_e   state_q;
  hsc_cmd_t cmd_q;
  logic     ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      ready_q <= 1'b1;
    end else begin
      cmd_q <= '0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire_i) begin
            ready_q    <= 1'b0;
            cmd_q.load <= 1'b1;
            state_q    <= S_LOAD;
          end
        end
        S_LOAD: state_q <= S_NEXT;
        S_NEXT: begin
          if (sts_i.jobs_left) begin
            cmd_q.pick <= 1'b1;
            state_q    <= S_DIFF;
          end else begin
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_DIFF: begin
          cmd_q.mul <= 1'b1;
          state_q   <= S_MUL;
        end
        S_MUL: begin
          cmd_q.sum <= 1'b1;
          state_q   <= S_SUM;
        end
        S_SUM: begin
          cmd_q.div_go <= 1'b1;
          state_q      <= S_DIVS;
        end
        S_DIVS: begin
          if (sts_i.div_done) begin
            cmd_q.sqrt_go <= 1'b1;
            state_q       <= S_SQS;
          end
        end
        S_SQS: begin
          if (sts_i.sqrt_done) begin
            cmd_q.sqrt_go   <= 1'b1;
            cmd_q.sqrt_curv <= 1'b1;
            state_q         <= S_SQC;
          end
        end
        S_SQC: begin
          if (sts_i.sqrt_done) begin
            cmd_q.div_go   <= 1'b1;
            cmd_q.div_curv <= 1'b1;
            state_q        <= S_DIVC;
          end
        end
        S_DIVC: begin
          if (sts_i.div_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (sts_i.out_free) begin
            cmd_q.emit <= 1'b1;
            state_q    <= S_NEXT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_o      = cmd_q;
  assign in_ready_o = ready_q;
endmodule

>>> rtl/hsc_dp.sv
// Datapath: config, raster counters, line stores, 3x3 window and cell arithmetic.
`timescale 1ns / 1ps
module hsc_dp import hsc_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  input  logic                          in_fire_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  hsc_cmd_t                      cmd_i,
  output hsc_sts_t                      sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [SLOPE_W-1:0]            slope_o,
  output logic [CURV_W-1:0]             curv_o,
  output logic [POS_W-1:0]              col_o,
  output logic [POS_W-1:0]              row_o,
  output logic                          last_run_o,
  output logic                          last_grid_o
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [DIM_W-1:0] W_CAP = (MAX_WIDTH < 1024) ? DIM_W'(MAX_WIDTH) : POS_LIMIT;

  typedef logic [2:0][SAMPLE_BITS-1:0] row_t;

  function automatic logic signed [EXT_W-1:0] sx(input logic [SAMPLE_BITS-1:0] v);
    return {{(EXT_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
  endfunction

  function automatic logic [EXT_W-1:0] mag(input logic signed [EXT_W-1:0] v);
    return v[EXT_W-1] ? EXT_W'(-v) : EXT_W'(v);
  endfunction

  // configuration
  logic [DIM_W-1:0]  width_q, height_q, w_eff, h_eff;
  logic [TILE_W-1:0] tile_q, t_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GRID_WIDTH_RST;
      height_q <= GRID_HEIGHT_RST;
      tile_q   <= TILE_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_GRID_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_TILE_SIZE:   tile_q   <= cfg_data_i[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0)       w_eff = DIM_W'(1);
    else if (width_q > W_CAP) w_eff = W_CAP;
    else                     w_eff = width_q;
    if (height_q == '0)          h_eff = DIM_W'(1);
    else if (height_q > POS_LIMIT) h_eff = POS_LIMIT;
    else                         h_eff = height_q;
    t_eff = (tile_q == '0) ? TILE_W'(1) : tile_q;
  end

  // raster position of the incoming sample, restarted if the grid shrank
  logic [POS_W-1:0] col_q, row_q, c_now, r_now, c_q, r_q;
  logic [DIM_W-1:0] row_inc;

  always_comb begin
    if ({1'b0, col_q} >= w_eff) begin
      c_now   = '0;
      row_inc = {1'b0, row_q} + 1'b1;
    end else begin
      c_now   = col_q;
      row_inc = {1'b0, row_q};
    end
    r_now = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
  end

  logic [SAMPLE_BITS-1:0] smp_q, older_rd, newer_rd, mid, top;
  logic                   last_col, last_row;
  logic [DIM_W-1:0]       col_nx, row_nx;

  always_comb begin
    mid      = (r_q != '0) ? newer_rd : smp_q;
    top      = (r_q >= POS_W'(2)) ? older_rd : mid;
    last_col = ({1'b0, c_q} == w_eff - 1'b1);
    last_row = ({1'b0, r_q} == h_eff - 1'b1);
    col_nx   = {1'b0, c_q} + 1'b1;
    row_nx   = {1'b0, r_q} + 1'b1;
  end

  hsc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(AW'(c_q)),
    .wdata_i(mid),
    .re_i   (in_fire_i),
    .raddr_i(AW'(c_now)),
    .rdata_o(older_rd)
  );

  hsc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_newer (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(AW'(c_q)),
    .wdata_i(smp_q),
    .re_i   (in_fire_i),
    .raddr_i(AW'(c_now)),
    .rdata_o(newer_rd)
  );

  // window rows: 0 holds the oldest row, 2 the sample row; column 2 is newest
  row_t [2:0] win_q;
  logic [3:0] job_q;
  logic [1:0] jsel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      job_q <= '0;
      win_q <= '0;
    end else if (cmd_i.load) begin
      if (c_q == '0) begin
        win_q[0] <= {3{top}};
        win_q[1] <= {3{mid}};
        win_q[2] <= {3{smp_q}};
      end else begin
        win_q[0] <= {top, win_q[0][2], win_q[0][1]};
        win_q[1] <= {mid, win_q[1][2], win_q[1][1]};
        win_q[2] <= {smp_q, win_q[2][2], win_q[2][1]};
      end
      job_q[0] <= (r_q != '0) && (c_q != '0);
      job_q[1] <= (r_q != '0) && last_col;
      job_q[2] <= last_row && (c_q != '0);
      job_q[3] <= last_row && last_col;
      if (col_nx >= w_eff) begin
        col_q <= '0;
        row_q <= (row_nx >= h_eff) ? '0 : row_nx[POS_W-1:0];
      end else begin
        col_q <= col_nx[POS_W-1:0];
        row_q <= r_q;
      end
    end else if (cmd_i.pick) begin
      job_q <= job_q & ~(4'b0001 << jsel);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      smp_q <= sample_i;
      c_q   <= c_now;
      r_q   <= r_now;
    end
  end

  // pick the next pending cell; upper job bits shift the stencil down/right
  row_t                   rw_d, rw_c, rw_u;
  logic [SAMPLE_BITS-1:0] hc, hl, hr, hd, hu, hdl, hdr, hul, hur;
  logic [EXT_W-1:0]       mag_a, mag_b, mag_x, mag_z, mag_e;

  always_comb begin
    priority if (job_q[0]) jsel = 2'd0;
    else if (job_q[1])     jsel = 2'd1;
    else if (job_q[2])     jsel = 2'd2;
    else                   jsel = 2'd3;
    rw_d = jsel[1] ? win_q[1] : win_q[0];
    rw_c = jsel[1] ? win_q[2] : win_q[1];
    rw_u = win_q[2];
    hl  = jsel[0] ? rw_c[1] : rw_c[0];
    hc  = jsel[0] ? rw_c[2] : rw_c[1];
    hr  = rw_c[2];
    hd  = jsel[0] ? rw_d[2] : rw_d[1];
    hdl = jsel[0] ? rw_d[1] : rw_d[0];
    hdr = rw_d[2];
    hu  = jsel[0] ? rw_u[2] : rw_u[1];
    hul = jsel[0] ? rw_u[1] : rw_u[0];
    hur = rw_u[2];
    mag_a = mag(sx(hr) - sx(hl));
    mag_b = mag(sx(hu) - sx(hd));
    mag_x = mag(sx(hr) - (sx(hc) <<< 1) + sx(hl));
    mag_z = mag(sx(hu) - (sx(hc) <<< 1) + sx(hd));
    mag_e = mag(sx(hur) - sx(hul) - sx(hdr) + sx(hdl));
  end

  logic [DIF_W-1:0]  a_q, b_q;
  logic [CD_W-1:0]   xx_q, zz_q, e_q;
  logic [POS_W-1:0]  pcol_q, prow_q;
  logic              plast_run_q, plast_grid_q;
  logic [2*DIF_W-1:0] a2_q, b2_q, t2_q;
  logic [2*D_W-1:0]  d2_q;
  logic [2*CD_W-1:0] xx2_q, zz2_q, e2_q;
  logic [P_W-1:0]    p_q;
  logic [M_W-1:0]    m_q;
  logic [S_W-1:0]    s_q, s_raw;
  logic [D_W-1:0]    d_val;

  assign d_val = {t_eff, 1'b0};
  assign s_raw = {t2_q, 16'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      a_q          <= DIF_W'(mag_a);
      b_q          <= DIF_W'(mag_b);
      xx_q         <= CD_W'(mag_x);
      zz_q         <= CD_W'(mag_z);
      e_q          <= CD_W'(mag_e);
      pcol_q       <= jsel[0] ? c_q : c_q - 1'b1;
      prow_q       <= jsel[1] ? r_q : r_q - 1'b1;
      plast_grid_q <= (jsel == 2'd3);
      plast_run_q  <= ((job_q & ~(4'b0001 << jsel)) == 4'b0000);
    end
    if (cmd_i.mul) begin
      a2_q  <= a_q * a_q;
      b2_q  <= b_q * b_q;
      t2_q  <= t_eff * t_eff;
      d2_q  <= d_val * d_val;
      xx2_q <= xx_q * xx_q;
      zz2_q <= zz_q * zz_q;
      e2_q  <= e_q * e_q;
    end
    if (cmd_i.sum) begin
      p_q <= P_W'(d2_q) + P_W'(a2_q) + P_W'(b2_q);
      m_q <= M_W'({xx2_q, 4'b0}) + M_W'({zz2_q, 4'b0}) + M_W'({e2_q, 1'b0});
      s_q <= (s_raw < CURV_MIN) ? CURV_MIN : s_raw;
    end
  end

  // shared iterative units
  logic [NUM_W-1:0]     div_num, div_quo;
  logic [S_W-1:0]       div_den;
  logic                 div_done, sqrt_done;
  logic [ROOT_IN_W-1:0] sqrt_val;
  logic [ROOT_W-1:0]    root;

  assign div_num  = cmd_i.div_curv ? NUM_W'({root, {CURV_FRAC{1'b0}}}) : {d2_q, 32'b0};
  assign div_den  = cmd_i.div_curv ? s_q : S_W'(p_q);
  assign sqrt_val = cmd_i.sqrt_curv ? {m_q, {CURV_SH{1'b0}}} : ROOT_IN_W'(div_quo[X_W-1:0]);

  hsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  hsc_isqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_go),
    .val_i  (sqrt_val),
    .done_o (sqrt_done),
    .root_o (root)
  );

  // slope = 1 - sqrt(X), captured when the slope root finishes
  logic                 sqrt_curv_q;
  logic [SLOPE_W:0]     slope_full;
  logic [SLOPE_W-1:0]   slope_q;
  logic [CURV_W-1:0]    curv_sat;

  assign slope_full = {1'b1, {SLOPE_W{1'b0}}} - root[SLOPE_W:0];
  assign curv_sat   = (|div_quo[NUM_W-1:CURV_W]) ? CURV_MAX : div_quo[CURV_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_go) begin
      sqrt_curv_q <= cmd_i.sqrt_curv;
    end
    if (sqrt_done && !sqrt_curv_q) begin
      slope_q <= slope_full[SLOPE_W] ? {SLOPE_W{1'b1}} : slope_full[SLOPE_W-1:0];
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      slope_o     <= slope_q;
      curv_o      <= curv_sat;
      col_o       <= pcol_q;
      row_o       <= prow_q;
      last_run_o  <= plast_run_q;
      last_grid_o <= plast_grid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.jobs_left = |job_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
endmodule

>>> rtl/heightmap_slope_curvature.sv
// Top level of the heightmap slope and curvature stencil.
//
//   channel     dir  handshake        payload
//   sample_ch   in   valid/ready      height_sample (signed Q8.8)
//   result_ch   out  valid/ready      slope, curvature, cell_col, cell_row,
//                                     last_of_run, last_of_grid
//   cfg         in   cfg_we_i only    cfg_idx_i, cfg_data_i
//
// A sample enters the window, then releases 0 to 4 results; each result takes
// two 66-step divides and two 32-step square roots, run in turn on one shared
// divider and one shared root unit.
// Reset leaves the block ready with grid 64 x 64 and tile 1.0; line stores are
// not cleared and hold whatever was last written.
// A stalled result sits in the output register while the next sample enters;
// a further result waits in the sequencer until the earlier beat is taken.
`timescale 1ns / 1ps
module heightmap_slope_curvature import hsc_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsc_sample_if.sink           sample_ch,
  hsc_result_if.source         result_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);
  hsc_cmd_t cmd;
  hsc_sts_t sts;
  logic     in_ready;
  logic     in_fire;

  // a sample beat moves when the sequencer is idle and the source offers one
  assign in_fire         = sample_ch.valid && in_ready;
  assign sample_ch.ready = in_ready;

  hsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_ready_o(in_ready)
  );

  hsc_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_fire_i  (in_fire),
    .sample_i   (sample_ch.height_sample),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_ready_i(result_ch.ready),
    .out_valid_o(result_ch.valid),
    .slope_o    (result_ch.slope),
    .curv_o     (result_ch.curvature),
    .col_o      (result_ch.cell_col),
    .row_o      (result_ch.cell_row),
    .last_run_o (result_ch.last_of_run),
    .last_grid_o(result_ch.last_of_grid)
  );
endmodule

>>> rtl/hsc_chk.sv
// Port-level checker for the slope and curvature block, with its bind.
`timescale 1ns / 1ps
`include "heightmap_slope_curvature_defines.svh"
module hsc_chk import hsc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [SLOPE_W-1:0] out_slope_i,
  input logic [CURV_W-1:0]  out_curv_i,
  input logic [POS_W-1:0]   out_col_i,
  input logic [POS_W-1:0]   out_row_i,
  input logic               out_last_run_i,
  input logic               out_last_grid_i
);
  // one sample at a time: the sequencer drops ready right after a sample beat
  `HSC_ASSERT_NEXT(a_ready_drops, in_valid_i && in_ready_i, !in_ready_i)
  // the grid's final cell always closes its run
  `HSC_ASSERT_IMPL(a_grid_end_run, out_valid_i && out_last_grid_i, out_last_run_i)
  `HSC_ASSERT_NEXT(a_out_holds, out_valid_i && !out_ready_i, out_valid_i)
  `HSC_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i,
                   $stable(out_slope_i) && $stable(out_curv_i) &&
                   $stable(out_col_i) && $stable(out_row_i))
endmodule

bind heightmap_slope_curvature hsc_chk u_hsc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_ch.valid),
  .in_ready_i     (sample_ch.ready),
  .out_valid_i    (result_ch.valid),
  .out_ready_i    (result_ch.ready),
  .out_slope_i    (result_ch.slope),
  .out_curv_i     (result_ch.curvature),
  .out_col_i      (result_ch.cell_col),
  .out_row_i      (result_ch.cell_row),
  .out_last_run_i (result_ch.last_of_run),
  .out_last_grid_i(result_ch.last_of_grid)
);

>>> dv/tb.sv
// Self-checking testbench of the heightmap slope and curvature stencil.
`timescale 1ns / 1ps
module tb;
  import hsc_pkg::*;

  localparam int  CLK_HALF    = 4;
  localparam int  SETTLE_CYC  = 1000;
  localparam int  HOLD_CYC    = 3000;
  localparam int  RAND_ITEMS  = 80;
  localparam longint CYC_LIMIT = 6000000;

  typedef enum {ROW_CFG, ROW_SAMPLE} row_op_e;

  // One directed row: a register setup (a = width, b = height, c = tile) or a
  // sample (a); flat marks rows whose results are known to be level ground.
  typedef struct {
    row_op_e op;
    int      a;
    int      b;
    int      c;
    bit      flat;
  } dir_row_t;

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [CURV_W-1:0]  curvature;
    logic [POS_W-1:0]   cell_col;
    logic [POS_W-1:0]   cell_row;
    logic               last_of_run;
    logic               last_of_grid;
  } cell_result_t;

  // Zero dimensions and tile, two-by-two extremes, one row, one column, flat.
  dir_row_t dir_rows[24] = '{
    '{ROW_CFG, 0, 0, 0, 0},
    '{ROW_SAMPLE, 32767, 0, 0, 1}, '{ROW_SAMPLE, -32768, 0, 0, 1},
    '{ROW_CFG, 2, 2, 65535, 0},
    '{ROW_SAMPLE, -32768, 0, 0, 0}, '{ROW_SAMPLE, 32767, 0, 0, 0},
    '{ROW_SAMPLE, 32767, 0, 0, 0}, '{ROW_SAMPLE, -32768, 0, 0, 0},
    '{ROW_CFG, 4, 1, 1, 0},
    '{ROW_SAMPLE, 0, 0, 0, 0}, '{ROW_SAMPLE, 32767, 0, 0, 0},
    '{ROW_SAMPLE, -32768, 0, 0, 0}, '{ROW_SAMPLE, 100, 0, 0, 0},
    '{ROW_CFG, 1, 3, 256, 0},
    '{ROW_SAMPLE, 5, 0, 0, 0}, '{ROW_SAMPLE, -5, 0, 0, 0},
    '{ROW_SAMPLE, 32767, 0, 0, 0},
    '{ROW_CFG, 3, 2, 256, 0},
    '{ROW_SAMPLE, 7, 0, 0, 1}, '{ROW_SAMPLE, 7, 0, 0, 1}, '{ROW_SAMPLE, 7, 0, 0, 1},
    '{ROW_SAMPLE, 7, 0, 0, 1}, '{ROW_SAMPLE, 7, 0, 0, 1}, '{ROW_SAMPLE, 7, 0, 0, 1}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  hsc_sample_if sample_ch ();
  hsc_result_if result_ch ();

  heightmap_slope_curvature DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_ch  (sample_ch),
    .result_ch  (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Mirror of the block state: registers, line stores, window, raster position.
  logic [DIM_W-1:0]  grid_w_reg;
  logic [DIM_W-1:0]  grid_h_reg;
  logic [TILE_W-1:0] tile_reg;
  longint            older_row [1024];
  longint            newer_row [1024];
  longint            win [3][3];
  int                in_col;
  int                in_row;

  cell_result_t pending_cells[$];
  int           err_cnt;
  int           checked_cnt;
  int           sample_cnt;
  int           setup_cnt;
  int           tx_idle_pct;
  int           rx_stall_pct;
  bit           hold_req;
  int           hold_left;
  longint       cyc_cnt;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Slope and curvature of one cell from the window rows and columns given.
  function automatic cell_result_t cell_terrain(int rd, int rc, int ru, int cl, int cc,
                                                int cr, int col, int row, bit grid_end);
    cell_result_t res;
    logic [127:0] t, a, b, d, p, x, q, xx, zz, e, m, r, s, cv;
    t  = (tile_reg == 0) ? 128'd1 : 128'(tile_reg);
    a  = 128'(mag(win[rc][cr] - win[rc][cl]));
    b  = 128'(mag(win[ru][cc] - win[rd][cc]));
    d  = 2 * t;
    p  = d * d + a * a + b * b;
    x  = ((d * d) << 32) / p;
    q  = 128'(int_sqrt(x[63:0]));
    res.slope = (65536 - q > 65535) ? 16'hFFFF : 16'(65536 - q);
    xx = 128'(mag(win[rc][cr] - 2 * win[rc][cc] + win[rc][cl]));
    zz = 128'(mag(win[ru][cc] - 2 * win[rc][cc] + win[rd][cc]));
    e  = 128'(mag(win[ru][cr] - win[ru][cl] - win[rd][cr] + win[rd][cl]));
    m  = 16 * xx * xx + 16 * zz * zz + 2 * e * e;
    r  = 128'(int_sqrt(64'(m << 24)));
    s  = (t * t) << 16;
    if (s < 128'(CURV_MIN)) s = 128'(CURV_MIN);
    cv = (r << CURV_FRAC) / s;
    res.curvature    = (cv > 128'(CURV_MAX)) ? CURV_MAX : cv[CURV_W-1:0];
    res.cell_col     = POS_W'(col);
    res.cell_row     = POS_W'(row);
    res.last_of_run  = 1'b0;
    res.last_of_grid = grid_end;
    return res;
  endfunction

  // Advance the mirror by one accepted sample and queue the cells it releases.
  task automatic predict_terrain(input logic signed [SAMPLE_BITS-1:0] smp_in, input bit flat);
    int           w, h, c, r, n;
    longint       smp, mid, top;
    cell_result_t cells[4];
    w = grid_w_reg;
    h = grid_h_reg;
    n = 0;
    if (w < 1) w = 1;
    if (w > 1024) w = 1024;
    if (h < 1) h = 1;
    if (h > 1024) h = 1024;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (in_row >= h) in_row = 0;
    c   = in_col;
    r   = in_row;
    smp = smp_in;
    mid = (r >= 1) ? newer_row[c] : smp;
    top = (r >= 2) ? older_row[c] : mid;
    for (int k = 0; k < 3; k++) begin
      if (c == 0) begin
        win[0][k] = top;
        win[1][k] = mid;
        win[2][k] = smp;
      end else begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = smp;
    older_row[c] = mid;
    newer_row[c] = smp;
    if (r >= 1) begin
      if (c >= 1) cells[n++] = cell_terrain(0, 1, 2, 0, 1, 2, c - 1, r - 1, 0);
      if (c == w - 1) cells[n++] = cell_terrain(0, 1, 2, 1, 2, 2, c, r - 1, 0);
    end
    if (r == h - 1) begin
      if (c >= 1) cells[n++] = cell_terrain(1, 2, 2, 0, 1, 2, c - 1, r, 0);
      if (c == w - 1) cells[n++] = cell_terrain(1, 2, 2, 1, 2, 2, c, r, 1);
    end
    if (n > 0) cells[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) begin
      // level ground: no slope and no curvature
      if (flat) begin
        cells[i].slope     = '0;
        cells[i].curvature = '0;
      end
      pending_cells.push_back(cells[i]);
    end
    in_col = c + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row = r + 1;
      if (in_row >= h) in_row = 0;
    end
  endtask

  // Offer one sample, idling first at the phase rate; valid stays high after
  // the beat so back-to-back beats never lower and raise it in one step.
  task automatic send_height(input logic signed [SAMPLE_BITS-1:0] v, input bit flat);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.height_sample <= v;
    do @(posedge clk_i); while (!sample_ch.ready);
    sample_cnt++;
    predict_terrain(v, flat);
  endtask

  // Drop valid, hold until every queued cell has come out, then let the block settle.
  task automatic drain_terrain();
    sample_ch.valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive edges while the block is idle.
  task automatic setup_grid(input int w, input int h, input int t);
    drain_terrain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_GRID_WIDTH;
    cfg_data <= CFG_W'(w);
    @(posedge clk_i);
    cfg_idx  <= CFG_GRID_HEIGHT;
    cfg_data <= CFG_W'(h);
    @(posedge clk_i);
    cfg_idx  <= CFG_TILE_SIZE;
    cfg_data <= CFG_W'(t);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    grid_w_reg = DIM_W'(w);
    grid_h_reg = DIM_W'(h);
    tile_reg   = TILE_W'(t);
    setup_cnt++;
  endtask

  function automatic int pick_tile();
    case ($urandom_range(4))
      0: return 0;
      1: return 1;
      2: return 65535;
      3: return 256;
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_height(bit smooth);
    if (smooth) return SAMPLE_BITS'($urandom_range(1023)) - SAMPLE_BITS'(512);
    return SAMPLE_BITS'($urandom);
  endfunction

  // Receiver: check every result beat against the oldest queued cell, then
  // decide ready for the next edge (random stalls or one long hold-off).
  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      cell_result_t got, want;
      got = '{result_ch.slope, result_ch.curvature, result_ch.cell_col,
              result_ch.cell_row, result_ch.last_of_run, result_ch.last_of_grid};
      if (pending_cells.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat %p", $time, got);
      end else begin
        want = pending_cells.pop_front();
        checked_cnt++;
        if (got !== want) begin
          err_cnt++;
          $display("%0t: result mismatch expected %p actual %p", $time, want, got);
        end
      end
    end
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Run limit, generous against the slowest legal run.
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("** heightmap_slope_curvature: FAILED **");
      $finish;
    end
  end

  initial begin
    int rand_done;
    int grid_idx;
    int w, h;
    bit smooth;
    rst_ni                  = 1'b0;
    sample_ch.valid         = 1'b0;
    sample_ch.height_sample = '0;
    result_ch.ready         = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = CFG_GRID_WIDTH;
    cfg_data                = '0;
    err_cnt = 0; checked_cnt = 0; sample_cnt = 0; setup_cnt = 0;
    tx_idle_pct = 0; rx_stall_pct = 0; hold_req = 1'b0; hold_left = 0; cyc_cnt = 0;
    grid_w_reg = GRID_WIDTH_RST;
    grid_h_reg = GRID_HEIGHT_RST;
    tile_reg   = TILE_SIZE_RST;
    in_col = 0;
    in_row = 0;
    foreach (win[i, j]) win[i][j] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG)
        setup_grid(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c);
      else
        send_height(SAMPLE_BITS'(dir_rows[i].a), dir_rows[i].flat);
    end

    // Random grids, cycling through the idle phases; the third grid gets the
    // long receiver hold-off while samples keep coming.
    rand_done = 0;
    grid_idx  = 0;
    while (rand_done < RAND_ITEMS) begin
      w = (grid_idx == 2) ? 4 : $urandom_range(1, 6);
      h = (grid_idx == 2) ? 4 : $urandom_range(1, 5);
      setup_grid(w, h, pick_tile());
      case (grid_idx % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      if (grid_idx == 2) hold_req = 1'b1;
      smooth = ($urandom_range(3) != 0);
      for (int k = 0; k < w * h; k++) begin
        send_height(pick_height(smooth), 1'b0);
        rand_done++;
      end
      grid_idx++;
    end

    drain_terrain();
    $display("Covered %0d samples over %0d register setups, %0d cell results checked,",
             sample_cnt, setup_cnt, checked_cnt);
    $display("with idle and stall phases and one long output hold-off.");
    if (err_cnt == 0) begin
      $display("** heightmap_slope_curvature: PASSED **");
    end else begin
      $display("** heightmap_slope_curvature: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/hsc_pkg.sv
rtl/hsc_if.sv
rtl/hsc_ram.sv
rtl/hsc_div.sv
rtl/hsc_isqrt.sv
rtl/hsc_ctrl.sv
rtl/hsc_dp.sv
rtl/heightmap_slope_curvature.sv
rtl/hsc_chk.sv
dv/tb.sv
